/* hdl/gaussian_sobel_edge_front_end_unit_assert.svh */
// Assertion macros used by the result queue of the edge front end.
`ifndef GAUSSIAN_SOBEL_EDGE_FRONT_END_UNIT_ASSERT_SVH
`define GAUSSIAN_SOBEL_EDGE_FRONT_END_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GSEF_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gsef assertion failed");
`define GSEF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gsef assertion failed");
`else
`define GSEF_ASSERT_NOW(label, clk, rst_n, pre, post)
`define GSEF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hdl/gsef_pkg.sv */
// Shared types and constants of the Gaussian and Sobel edge front end.
`default_nettype none
package gsef_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 10;
    localparam int MAG_W     = 11;
    localparam int DIR_W     = 2;
    localparam int IMG_W_W   = 11;

    localparam logic [ROW_W-1:0]   IMAGE_WIDTH_RST  = 16'd82;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST11 = 11'd82;
    localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd82;

    // Register indexes on the configuration port.
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

    // Fixed point tangent thresholds, scaled by 65536.
    localparam logic [27:0] TAN_LO_COEF = 28'd27146;
    localparam logic [27:0] TAN_HI_COEF = 28'd158218;

    // 3x3 window, row major, top row first.
    typedef logic [8:0][7:0] t_win;

    typedef struct packed {
        logic                 c_ge2;
        logic                 c_ge3;
        logic                 r_ge3;
        logic                 last_col;
        logic                 last_row;
        logic [ROW_W-1:0]     row_m2;
        logic [ROW_W-1:0]     row_m1;
        logic [OUT_COL_W-1:0] col_m2;
        logic [OUT_COL_W-1:0] col_m1;
    } t_pos;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [MAG_W-1:0]     magnitude;
        logic [DIR_W-1:0]     direction;
        logic                 frame_last;
    } t_result;

endpackage
`default_nettype wire

/* hdl/gaussian_sobel_edge_front_end_unit.sv */
// Top level of the Gaussian blur and Sobel gradient edge front end.
//
// Pixels enter on i_pixel in raster order under i_valid/o_ready; a transfer
// happens when both are high. Each frame is image_height rows of image_width
// pixels, both set through the APB port (width at 0x0, height at 0x4).
// For every interior position of the blurred image one result leaves on the
// o_valid/i_ready channel: row, column, |Gx|+|Gy| and a direction code, with
// o_frame_last on the final result of a frame.
// A result passes the stage-1 registers, the blurred window, the result queue
// and the output register. One pixel is taken every cycle while the queue is
// free; a pixel that ends a row or lies in the last row gives two results and
// the last pixel of a frame four, and the input waits while the extra results
// leave, as the output register moves one result per cycle while i_ready is high.
// Reset clears the position to row 0, column 0, clears both windows and sets
// both sizes to 82. The line stores need no clearing: each entry is written
// before its value is used. When the receiver holds i_ready low the output holds
// and o_ready drops once the result buffer is full.
`default_nettype none
module gaussian_sobel_edge_front_end_unit
    import gsef_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_psel,
    input  wire                  i_penable,
    input  wire                  i_pwrite,
    input  wire  [2:0]           i_paddr,
    input  wire  [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_pixel,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [OUT_COL_W-1:0] o_out_col,
    output logic [MAG_W-1:0]     o_magnitude,
    output logic [DIR_W-1:0]     o_direction,
    output logic                 o_frame_last
);
    localparam int EWW = $clog2(MAX_WIDTH+1);

    logic [IMG_W_W-1:0] r_image_width;
    logic [ROW_W-1:0]   r_image_height;
    logic [EWW-1:0]     eff_width;
    logic [ROW_W-1:0]   eff_height;

    logic       en;
    logic       accept;
    logic       s2_valid;
    t_pos       s2_pos;
    t_win       blur_win;
    t_win       lane_win [4];
    logic [MAG_W-1:0] lane_mag [4];
    logic [DIR_W-1:0] lane_dir [4];
    t_result    slot [4];
    logic [3:0] mask;
    t_result    result;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST11;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[2])
                REG_IDX_WIDTH:  r_image_width  <= i_pwdata[IMG_W_W-1:0];
                REG_IDX_HEIGHT: r_image_height <= i_pwdata[ROW_W-1:0];
                default:        r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_IDX_WIDTH:  o_prdata = 32'(r_image_width);
            REG_IDX_HEIGHT: o_prdata = 32'(r_image_height);
            default:        o_prdata = '0;
        endcase
        if (r_image_width < 11'd3) begin
            eff_width = EWW'(3);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            eff_width = EWW'(MAX_WIDTH);
        end else begin
            eff_width = EWW'(r_image_width);
        end
        eff_height = (r_image_height < 16'd3) ? 16'd3 : r_image_height;
    end

    assign o_ready = en;
    assign accept  = i_valid && en;

    gsef_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_eff_width  (eff_width),
        .i_eff_height (eff_height),
        .o_s2_valid   (s2_valid),
        .o_s2_pos     (s2_pos),
        .o_blur_win   (blur_win)
    );

    // The right column and bottom row of the blurred image are zero, so the
    // edge positions see shifted copies of the window with zeros filled in.
    always_comb begin
        lane_win[0] = blur_win;
        lane_win[1] = '0;
        lane_win[2] = '0;
        lane_win[3] = '0;
        for (int i = 0; i < 3; i++) begin
            lane_win[1][i*3]   = blur_win[i*3+1];
            lane_win[1][i*3+1] = blur_win[i*3+2];
        end
        for (int i = 0; i < 6; i++) begin
            lane_win[2][i] = blur_win[i+3];
        end
        for (int i = 0; i < 2; i++) begin
            lane_win[3][i*3]   = blur_win[(i+1)*3+1];
            lane_win[3][i*3+1] = blur_win[(i+1)*3+2];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        gsef_gradient u_gradient (
            .i_win       (lane_win[k]),
            .o_magnitude (lane_mag[k]),
            .o_direction (lane_dir[k])
        );
    end

    always_comb begin
        mask[0] = s2_valid && s2_pos.c_ge3 && s2_pos.r_ge3;
        mask[1] = s2_valid && s2_pos.c_ge2 && s2_pos.r_ge3 && s2_pos.last_col;
        mask[2] = s2_valid && s2_pos.c_ge3 && s2_pos.last_row;
        mask[3] = s2_valid && s2_pos.c_ge2 && s2_pos.last_row && s2_pos.last_col;
        for (int k = 0; k < 4; k++) begin
            slot[k].row        = (k < 2) ? s2_pos.row_m2 : s2_pos.row_m1;
            slot[k].col        = (k == 0 || k == 2) ? s2_pos.col_m2 : s2_pos.col_m1;
            slot[k].magnitude  = lane_mag[k];
            slot[k].direction  = lane_dir[k];
            slot[k].frame_last = (k == 3);
        end
    end

    gsef_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s2_valid),
        .i_mask   (mask),
        .i_slot   (slot),
        .o_en     (en),
        .o_valid  (o_valid),
        .o_result (result),
        .i_ready  (i_ready)
    );

    assign o_out_row    = result.row;
    assign o_out_col    = result.col;
    assign o_magnitude  = result.magnitude;
    assign o_direction  = result.direction;
    assign o_frame_last = result.frame_last;
endmodule
`default_nettype wire

/* hdl/gsef_line_buf.sv */
// Two-bank line store with one registered read port and one write port.
`default_nettype none
module gsef_line_buf #(
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_bank0,
    output logic [7:0]               o_rd_bank1,
    input  wire                      i_wr_en,
    input  wire                      i_wr_bank,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [7:0]               i_wr_data
);
    logic [7:0] r_bank0 [DEPTH];
    logic [7:0] r_bank1 [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_bank0 <= r_bank0[i_rd_addr];
            o_rd_bank1 <= r_bank1[i_rd_addr];
        end
        if (i_wr_en && !i_wr_bank) begin
            r_bank0[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && i_wr_bank) begin
            r_bank1[i_wr_addr] <= i_wr_data;
        end
    end
endmodule
`default_nettype wire

/* hdl/gsef_window.sv */
// Position counters, line stores, raw and blurred 3x3 windows.
`default_nettype none
module gsef_window
    import gsef_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_accept,
    input  wire  [7:0]                       i_pixel,
    input  wire  [$clog2(MAX_WIDTH+1)-1:0]   i_eff_width,
    input  wire  [ROW_W-1:0]                 i_eff_height,
    output logic                             o_s2_valid,
    output t_pos                             o_s2_pos,
    output t_win                             o_blur_win
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EWW = $clog2(MAX_WIDTH+1);

    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;

    logic             wrap_col;
    logic [ROW_W:0]   row_a;
    logic [ROW_W-1:0] r0;
    logic [CW-1:0]    c0;
    logic [CW-1:0]    j0;
    logic             last_col;
    logic             last_row;
    t_pos             pos0;

    logic             r_s1_valid;
    logic             r_s1_sr;
    logic             r_s1_c_ge1;
    logic             r_s1_blur_on;
    logic [CW-1:0]    r_s1_j;
    logic [7:0]       r_s1_pixel;
    t_pos             r_s1_pos;
    logic             r_s2_valid;
    t_pos             r_s2_pos;

    t_win             r_raw_win;
    t_win             r_blur_win;
    t_win             raw_new;
    logic [11:0]      blur_sum;
    logic [7:0]       nb;

    logic [7:0] raw_q0, raw_q1, blur_q0, blur_q1;
    logic [7:0] up2, up1, blur_u, blur_v;
    logic       blur_wr;

    always_comb begin
        wrap_col = EWW'(r_col) >= i_eff_width;
        row_a    = wrap_col ? ({1'b0, r_row} + 17'd1) : {1'b0, r_row};
        r0       = (row_a >= {1'b0, i_eff_height}) ? '0 : row_a[ROW_W-1:0];
        c0       = wrap_col ? '0 : r_col;
        j0       = c0 - CW'(1);
        last_col = EWW'(c0) == (i_eff_width - EWW'(1));
        last_row = r0 == (i_eff_height - 16'd1);

        pos0.c_ge2    = c0 >= CW'(2);
        pos0.c_ge3    = c0 >= CW'(3);
        pos0.r_ge3    = r0 >= 16'd3;
        pos0.last_col = last_col;
        pos0.last_row = last_row;
        pos0.row_m2   = r0 - 16'd2;
        pos0.row_m1   = r0 - 16'd1;
        pos0.col_m2   = OUT_COL_W'(c0 - CW'(2));
        pos0.col_m1   = OUT_COL_W'(c0 - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r0 + 16'd1;
            end else begin
                r_col <= c0 + CW'(1);
                r_row <= r0;
            end
        end
    end

    // Raw rows two and one above are read while the new pixel overwrites the older one.
    gsef_line_buf #(.DEPTH(MAX_WIDTH)) u_raw_buf (
        .i_clk      (i_clk),
        .i_rd_en    (i_accept),
        .i_rd_addr  (c0),
        .o_rd_bank0 (raw_q0),
        .o_rd_bank1 (raw_q1),
        .i_wr_en    (i_accept),
        .i_wr_bank  (r0[0]),
        .i_wr_addr  (c0),
        .i_wr_data  (i_pixel)
    );

    gsef_line_buf #(.DEPTH(MAX_WIDTH)) u_blur_buf (
        .i_clk      (i_clk),
        .i_rd_en    (i_accept),
        .i_rd_addr  (j0),
        .o_rd_bank0 (blur_q0),
        .o_rd_bank1 (blur_q1),
        .i_wr_en    (blur_wr),
        .i_wr_bank  (~r_s1_sr),
        .i_wr_addr  (r_s1_j),
        .i_wr_data  (nb)
    );

    always_comb begin
        up2    = r_s1_sr ? raw_q1 : raw_q0;
        up1    = r_s1_sr ? raw_q0 : raw_q1;
        blur_u = r_s1_sr ? blur_q0 : blur_q1;
        blur_v = r_s1_sr ? blur_q1 : blur_q0;
        for (int i = 0; i < 3; i++) begin
            raw_new[i*3]   = r_raw_win[i*3+1];
            raw_new[i*3+1] = r_raw_win[i*3+2];
        end
        raw_new[2] = up2;
        raw_new[5] = up1;
        raw_new[8] = r_s1_pixel;
        blur_sum = 12'(raw_new[0]) + {3'b0, raw_new[1], 1'b0} + 12'(raw_new[2])
                 + {3'b0, raw_new[3], 1'b0} + {2'b0, raw_new[4], 2'b0}
                 + {3'b0, raw_new[5], 1'b0} + 12'(raw_new[6])
                 + {3'b0, raw_new[7], 1'b0} + 12'(raw_new[8]);
        nb      = r_s1_blur_on ? blur_sum[11:4] : 8'd0;
        blur_wr = i_en && r_s1_valid && r_s1_c_ge1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_raw_win  <= '0;
            r_blur_win <= '0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_raw_win <= raw_new;
                if (r_s1_c_ge1) begin
                    r_blur_win <= {nb, r_blur_win[8:7], blur_v,
                                   r_blur_win[5:4], blur_u, r_blur_win[2:1]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_sr      <= r0[0];
            r_s1_c_ge1   <= c0 != '0;
            r_s1_blur_on <= (r0 >= 16'd2) && pos0.c_ge2;
            r_s1_j       <= j0;
            r_s1_pixel   <= i_pixel;
            r_s1_pos     <= pos0;
            r_s2_pos     <= r_s1_pos;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2_pos   = r_s2_pos;
    assign o_blur_win = r_blur_win;
endmodule
`default_nettype wire

/* hdl/gsef_gradient.sv */
// Sobel gradient, magnitude and quantised direction of one 3x3 window.
`default_nettype none
module gsef_gradient
    import gsef_pkg::*;
(
    input  wire  t_win             i_win,
    output logic [MAG_W-1:0]       o_magnitude,
    output logic [DIR_W-1:0]       o_direction
);
    logic [9:0]  x_pos, x_neg, y_pos, y_neg;
    logic [9:0]  a, b;
    logic        neg_x, neg_y;
    logic [27:0] lhs, rhs_lo, rhs_hi;

    always_comb begin
        x_pos = 10'(i_win[2]) + {1'b0, i_win[5], 1'b0} + 10'(i_win[8]);
        x_neg = 10'(i_win[0]) + {1'b0, i_win[3], 1'b0} + 10'(i_win[6]);
        y_pos = 10'(i_win[6]) + {1'b0, i_win[7], 1'b0} + 10'(i_win[8]);
        y_neg = 10'(i_win[0]) + {1'b0, i_win[1], 1'b0} + 10'(i_win[2]);
        neg_x = x_pos < x_neg;
        neg_y = y_pos < y_neg;
        a     = neg_x ? x_neg - x_pos : x_pos - x_neg;
        b     = neg_y ? y_neg - y_pos : y_pos - y_neg;
        o_magnitude = {1'b0, a} + {1'b0, b};
        lhs    = {2'b0, a, 16'b0};
        rhs_lo = 28'(b) * TAN_LO_COEF;
        rhs_hi = 28'(b) * TAN_HI_COEF;
        if (lhs <= rhs_lo) begin
            o_direction = DIR_0;
        end else if (lhs >= rhs_hi) begin
            o_direction = DIR_90;
        end else if (neg_x == neg_y) begin
            o_direction = DIR_45;
        end else begin
            o_direction = DIR_135;
        end
    end
endmodule
`default_nettype wire

/* hdl/gsef_result_queue.sv */
// Holds the results of one pixel and hands them to the output register in order.
`default_nettype none
`include "gaussian_sobel_edge_front_end_unit_assert.svh"
module gsef_result_queue
    import gsef_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_load,
    input  wire  [3:0]     i_mask,
    input  wire  t_result  i_slot [4],
    output logic           o_en,
    output logic           o_valid,
    output t_result        o_result,
    input  wire            i_ready
);
    logic [3:0] r_mask;
    t_result    r_slot [4];
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       take;
    logic [1:0] head;
    logic [3:0] mask_after;

    always_comb begin
        if (r_mask[0]) begin
            head = 2'd0;
        end else if (r_mask[1]) begin
            head = 2'd1;
        end else if (r_mask[2]) begin
            head = 2'd2;
        end else begin
            head = 2'd3;
        end
        out_free   = !r_out_valid || i_ready;
        take       = (r_mask != 4'b0) && out_free;
        mask_after = take ? (r_mask & ~(4'b0001 << head)) : r_mask;
        // A new set of results may enter once the present set has all left.
        o_en       = mask_after == 4'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= 4'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= o_en ? (i_load ? i_mask : 4'b0) : mask_after;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_load) begin
            r_slot <= i_slot;
        end
        if (take) begin
            r_out <= r_slot[head];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `GSEF_ASSERT_NOW(a_empty_loads, i_clk, i_rst_n, r_mask == 4'b0, o_en)
    `GSEF_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, (r_mask != 4'b0) && !take, !o_en)
    `GSEF_ASSERT_NEXT(a_take_shows, i_clk, i_rst_n, take, r_out_valid)
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the Gaussian blur and Sobel gradient edge front end.
`default_nettype none
module tb_top;
    import gsef_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 470;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_psel = 1'b0;
    logic                 i_penable = 1'b0;
    logic                 i_pwrite = 1'b0;
    logic [2:0]           i_paddr = '0;
    logic [31:0]          i_pwdata = '0;
    logic [31:0]          o_prdata;
    logic                 o_pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_pixel = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [ROW_W-1:0]     o_out_row;
    logic [OUT_COL_W-1:0] o_out_col;
    logic [MAG_W-1:0]     o_magnitude;
    logic [DIR_W-1:0]     o_direction;
    logic                 o_frame_last;

    gaussian_sobel_edge_front_end_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata),
        .o_pready(o_pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_magnitude(o_magnitude),
        .o_direction(o_direction), .o_frame_last(o_frame_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gradient predictor state.
    logic [IMG_W_W-1:0] img_width;
    logic [ROW_W-1:0]   img_height;
    logic [7:0]         raw_rows [2*MAX_WIDTH_DEF];
    logic [7:0]         blur_rows [2*MAX_WIDTH_DEF];
    logic [7:0]         raw_win [9];
    logic [7:0]         blur_win [9];
    int unsigned        cur_row;
    int unsigned        cur_col;

    t_result gradients_due [$];
    int      mismatches = 0;
    int      pixels_sent = 0;

    function automatic int unsigned width_in_use();
        int unsigned w;
        w = img_width;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic int unsigned height_in_use();
        return (img_height < 3) ? 3 : img_height;
    endfunction

    function automatic void push_column(ref logic [7:0] win [9],
                                        input logic [7:0] top, mid, bot);
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
    endfunction

    function automatic t_result gradient_of(int unsigned y, int unsigned x,
                                            logic [7:0] g [9], logic last);
        t_result r;
        int gx, gy;
        longint ax, ay;
        gx = (int'(g[2]) + 2*int'(g[5]) + int'(g[8]))
           - (int'(g[0]) + 2*int'(g[3]) + int'(g[6]));
        gy = (int'(g[6]) + 2*int'(g[7]) + int'(g[8]))
           - (int'(g[0]) + 2*int'(g[1]) + int'(g[2]));
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        r.row        = y[ROW_W-1:0];
        r.col        = x[OUT_COL_W-1:0];
        r.magnitude  = MAG_W'(ax + ay);
        r.frame_last = last;
        if (65536 * ax <= longint'(TAN_LO_COEF) * ay)
            r.direction = DIR_0;
        else if (65536 * ax >= longint'(TAN_HI_COEF) * ay)
            r.direction = DIR_90;
        else
            r.direction = ((gx < 0) == (gy < 0)) ? DIR_45 : DIR_135;
        return r;
    endfunction

    // Advances the predictor by one pixel and returns the gradients it completes.
    function automatic void predict_pixel(logic [7:0] pix, ref t_result res [$]);
        int unsigned w, h, r, c, sr, so, j, s;
        logic [7:0] up2, up1, nb, u, v;
        logic [7:0] g [9];
        w = width_in_use();
        h = height_in_use();
        res.delete();
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r  = cur_row;
        c  = cur_col;
        sr = r & 1;
        so = sr ^ 1;
        up2 = raw_rows[sr*MAX_WIDTH_DEF + c];
        up1 = raw_rows[so*MAX_WIDTH_DEF + c];
        raw_rows[sr*MAX_WIDTH_DEF + c] = pix;
        push_column(raw_win, up2, up1, pix);
        if (c >= 1) begin
            j = c - 1;
            nb = 8'd0;
            if (r >= 2 && c >= 2) begin
                s = raw_win[0] + 2*raw_win[1] + raw_win[2] + 2*raw_win[3] + 4*raw_win[4]
                  + 2*raw_win[5] + raw_win[6] + 2*raw_win[7] + raw_win[8];
                nb = 8'(s / 16);
            end
            u = blur_rows[so*MAX_WIDTH_DEF + j];
            v = blur_rows[sr*MAX_WIDTH_DEF + j];
            blur_rows[so*MAX_WIDTH_DEF + j] = nb;
            push_column(blur_win, u, v, nb);
        end
        if (c >= 2) begin
            if (r >= 3 && c >= 3)
                res.push_back(gradient_of(r-2, c-2, blur_win, 1'b0));
            if (r >= 3 && c == w-1) begin
                for (int i = 0; i < 3; i++) begin
                    g[i*3]   = blur_win[i*3+1];
                    g[i*3+1] = blur_win[i*3+2];
                    g[i*3+2] = 8'd0;
                end
                res.push_back(gradient_of(r-2, w-2, g, 1'b0));
            end
            if (r == h-1) begin
                if (c >= 3) begin
                    for (int i = 0; i < 6; i++) g[i] = blur_win[i+3];
                    for (int i = 6; i < 9; i++) g[i] = 8'd0;
                    res.push_back(gradient_of(h-2, c-2, g, 1'b0));
                end
                if (c == w-1) begin
                    for (int i = 0; i < 9; i++) g[i] = 8'd0;
                    for (int i = 0; i < 2; i++) begin
                        g[i*3]   = blur_win[(i+1)*3+1];
                        g[i*3+1] = blur_win[(i+1)*3+2];
                    end
                    res.push_back(gradient_of(h-2, w-2, g, 1'b1));
                end
            end
        end
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endfunction

    // Register write: setup phase then access phase.
    task automatic write_reg(logic idx, logic [31:0] value);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b1;
        i_penable <= 1'b0;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_IDX_WIDTH) img_width = value[IMG_W_W-1:0];
        else img_height = value[ROW_W-1:0];
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (gradients_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(REG_IDX_WIDTH, {21'($urandom_range(0, 2097151)), w[IMG_W_W-1:0]});
        write_reg(REG_IDX_HEIGHT, {16'($urandom_range(0, 65535)), h[ROW_W-1:0]});
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int burst_left = 0;

    task automatic send_pixel(logic [7:0] pix, bit typed, t_result typed_res);
        t_result res [$];
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel(pix, res);
        if (typed) gradients_due.push_back(typed_res);
        else foreach (res[k]) gradients_due.push_back(res[k]);
        pixels_sent++;
    endtask

    function automatic logic [7:0] frame_pixel(int style, int unsigned r, int unsigned c);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return 8'(r * 37 + c * 11 + $urandom_range(0, 3));
            default: return (c > r) ? 8'hFF : 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_frame(int unsigned w, int unsigned h, int unsigned rows);
        int style;
        t_result none;
        style = $urandom_range(0, 3);
        none  = '0;
        for (int unsigned r = 0; r < rows; r++)
            for (int unsigned c = 0; c < w; c++)
                send_pixel(frame_pixel(style, r, c), 1'b0, none);
    endtask

    // Receiver stall pattern.
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(10, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= (rx_phase % 3) == 0;
            2: i_ready <= $urandom_range(0, 1);
            default: i_ready <= (rx_left > 8);
        endcase
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (gradients_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row %0d col %0d", o_out_row, o_out_col);
            end else begin
                want = gradients_due.pop_front();
                if (o_out_row !== want.row || o_out_col !== want.col
                    || o_magnitude !== want.magnitude || o_direction !== want.direction
                    || o_frame_last !== want.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected row %0d col %0d mag %0d dir %0d last %0d, got row %0d col %0d mag %0d dir %0d last %0d",
                                 want.row, want.col, want.magnitude, want.direction,
                                 want.frame_last, o_out_row, o_out_col, o_magnitude,
                                 o_direction, o_frame_last);
                end
            end
        end
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Directed stimulus table.
    typedef struct {
        logic [7:0] pix;
        bit         typed;
        t_result    res;
    } t_row;

    t_row dir_rows [25];

    initial begin
        int unsigned w, h, frames;
        for (int i = 0; i < 9; i++) begin
            dir_rows[i].pix   = (i % 2) ? 8'hFF : 8'h00;
            dir_rows[i].typed = 1'b0;
            dir_rows[i].res   = '0;
        end
        // In a 3x3 frame only the centre blurs to non-zero, so the gradient is flat.
        dir_rows[8].typed = 1'b1;
        dir_rows[8].res   = '{row: 16'd1, col: 10'd1, magnitude: '0,
                              direction: DIR_0, frame_last: 1'b1};
        for (int i = 9; i < 25; i++) begin
            dir_rows[i].pix   = ((i - 9) % 4 >= 2) ? 8'hFF : 8'h00;
            dir_rows[i].typed = 1'b0;
            dir_rows[i].res   = '0;
        end

        img_width  = IMAGE_WIDTH_RST11;
        img_height = IMAGE_HEIGHT_RST;
        foreach (raw_rows[k]) begin
            raw_rows[k]  = '0;
            blur_rows[k] = '0;
        end
        foreach (raw_win[k]) begin
            raw_win[k]  = '0;
            blur_win[k] = '0;
        end
        cur_row = 0;
        cur_col = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(3, 3);
        for (int i = 0; i < 25; i++) begin
            if (i == 9) begin
                wait_drained();
                set_size(4, 4);
            end
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
        end

        frames = 0;
        while (pixels_sent < RANDOM_PIXELS + 25) begin
            wait_drained();
            case (frames)
                2: begin
                    // Sizes below the minimum are raised to three.
                    set_size($urandom_range(0, 2), $urandom_range(0, 2));
                    send_frame(3, 3, 3);
                end
                11: begin
                    // Tallest frame, cut short: the next height restarts the frame.
                    set_size(5, 65535);
                    send_frame(5, 65535, 7);
                    wait_drained();
                    set_size(5, 3);
                    send_frame(5, 3, 3);
                end
                default: begin
                    w = $urandom_range(3, 12);
                    h = $urandom_range(3, 9);
                    set_size(w, h);
                    send_frame(w, h, h);
                end
            endcase
            frames++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && gradients_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/gsef_pkg.sv
hdl/gsef_line_buf.sv
hdl/gsef_window.sv
hdl/gsef_gradient.sv
hdl/gsef_result_queue.sv
hdl/gaussian_sobel_edge_front_end_unit.sv
test/tb_top.sv
